@@ src/slot_pool_allocator_assert.svh @@
// Assertion macros, clocked on clock, quiet during reset
`ifndef SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SPA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/spa_pkg.sv @@
package spa_pkg;

   localparam int POOL_SLOTS = 512;
   localparam int SLOT_W     = 9;
   localparam int HINT_W     = 10;
   localparam int WORD_BITS  = 32;
   localparam int WORDS      = POOL_SLOTS / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(WORDS);
   localparam int BIT_W      = $clog2(WORD_BITS);

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam logic [HINT_W-1:0] HINT_FULL = HINT_W'(POOL_SLOTS);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RELEASE,
      ST_GRANT,
      ST_SCAN
   } state_type;

endpackage

@@ src/slot_pool_allocator.sv @@
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_mode, req_slot_index
// rsp      out        rsp_valid/rsp_stall rsp_granted_slot, rsp_pool_full
//
// Allocate on a full pool: flagged full, no search. Release: read-modify-write of one mark word.
// Allocate: marks the granted slot, then scans its word and each further 32-slot word up to the last;
// the shared first-zero unit examines one word per cycle from the 1R1W mark RAM.
// Reset clears the sequencer, the hint and a valid flag per mark word; no clearing pass.
// The result register takes the grant on acceptance; a new request waits while it is stalled.
module slot_pool_allocator
   import spa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic              rsp_pool_full
);

   state_type state_ff, state_in;

   logic [HINT_W-1:0]     hint_ff, hint_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_full_ff, rsp_full_in;

   word_type              mem_ff [WORDS];
   logic [WORDS-1:0]      row_valid_ff;
   word_type              rd_data_ff;
   logic                  rd_valid_ff;
   logic [WORD_IDX_W-1:0] rd_addr;
   logic                  wr_en;
   logic [WORD_IDX_W-1:0] wr_addr;
   word_type              wr_data;

   word_type         word_view;
   word_type         bit_oh;
   word_type         search;
   logic             found;
   logic [BIT_W-1:0] pos;
   logic             last_word;
   logic             accept;
   logic             out_free;
   logic             rel_in_range;
   logic             pool_full_now;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign req_stall     = !((state_ff == ST_IDLE) && out_free);
   assign accept        = req_valid && !req_stall;
   assign rel_in_range  = HINT_W'(req_slot_index) < HINT_FULL;
   assign pool_full_now = hint_ff >= HINT_FULL;
   assign last_word     = word_ff == WORD_IDX_W'(WORDS - 1);

   assign word_view = rd_valid_ff ? rd_data_ff : '0;
   assign bit_oh    = word_type'(1) << slot_ff[BIT_W-1:0];

   // shared first-zero unit
   always_comb begin
      case (state_ff)
         ST_GRANT: search = word_view | bit_oh | ~(word_type'('1) << slot_ff[BIT_W-1:0]);
         ST_SCAN:  search = word_view;
         default:  search = '1;
      endcase
   end

   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!search[i]) begin
            found = 1'b1;
            pos   = BIT_W'(i);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_RELEASE) begin
                  state_in = rel_in_range ? ST_RELEASE : ST_IDLE;
               end else begin
                  state_in = pool_full_now ? ST_IDLE : ST_GRANT;
               end
            end
         end
         ST_RELEASE: state_in = ST_IDLE;
         ST_GRANT, ST_SCAN: begin
            state_in = (found || last_word) ? ST_IDLE : ST_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      hint_in      = hint_ff;
      slot_in      = slot_ff;
      word_in      = word_ff;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff[SLOT_W-1:BIT_W];
      wr_data      = word_view | bit_oh;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_RELEASE) begin
                  slot_in = req_slot_index;
                  rd_addr = req_slot_index[SLOT_W-1:BIT_W];
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_full_in  = pool_full_now;
                  rsp_slot_in  = pool_full_now ? '0 : hint_ff[SLOT_W-1:0];
                  slot_in      = hint_ff[SLOT_W-1:0];
                  word_in      = hint_ff[SLOT_W-1:BIT_W];
                  rd_addr      = hint_ff[SLOT_W-1:BIT_W];
               end
            end
         end
         ST_RELEASE: begin
            wr_en   = 1'b1;
            wr_data = word_view & ~bit_oh;
            if (HINT_W'(slot_ff) < hint_ff) begin
               hint_in = HINT_W'(slot_ff);
            end
         end
         ST_GRANT, ST_SCAN: begin
            wr_en = state_ff == ST_GRANT;
            if (found) begin
               hint_in = HINT_W'({word_ff, pos});
            end else if (last_word) begin
               hint_in = HINT_FULL;
            end else begin
               word_in = word_ff + WORD_IDX_W'(1);
               rd_addr = word_ff + WORD_IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      word_ff     <= word_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_full_ff <= rsp_full_in;
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   // mark RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_pool_full    = rsp_full_ff;

endmodule

@@ src/spa_checker.sv @@
`include "slot_pool_allocator_assert.svh"

module spa_checker
   import spa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_mode,
   input logic [SLOT_W-1:0] req_slot_index,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [SLOT_W-1:0] rsp_granted_slot,
   input logic              rsp_pool_full
);

   `SPA_ASSERT_NOW(a_full_zero, rsp_valid && rsp_pool_full, rsp_granted_slot == '0, "full result carries a nonzero slot")

   `SPA_ASSERT_NEXT(a_alloc_result, req_valid && !req_stall && req_mode == MODE_ALLOC, rsp_valid, "allocate transfer gave no result")

   `SPA_ASSERT_NEXT(a_release_busy, req_valid && !req_stall && req_mode == MODE_RELEASE && HINT_W'(req_slot_index) < HINT_FULL, req_stall, "release did not hold off the next transfer")

   `SPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_granted_slot) && $stable(rsp_pool_full), "stalled result changed")

endmodule

bind slot_pool_allocator spa_checker u_spa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .req_slot_index   (req_slot_index),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_pool_full    (rsp_pool_full)
);
